// File: rtl/sctlb_pkg.sv
`timescale 1ns / 1ps
package sctlb_pkg;
   localparam int TLB_ENTRIES_DEF = 32;
   localparam int NREGS = 32;
   localparam int IDX_W = 5;

   typedef enum logic [2:0] {
      OP_MF = 3'd0, OP_MT = 3'd1, OP_TLBR = 3'd2, OP_TLB_WRITE = 3'd3,
      OP_TLBP = 3'd4, OP_ERET = 3'd5, OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_SCAN, ST_DONE
   } state_type;

   localparam logic [4:0] R_INDEX = 5'd0, R_LO0 = 5'd2, R_LO1 = 5'd3,
      R_CONTEXT = 5'd4, R_PMASK = 5'd5, R_WIRED = 5'd6, R_COUNT = 5'd9, R_HI = 5'd10,
      R_COMPARE = 5'd11, R_STATUS = 5'd12, R_CAUSE = 5'd13, R_EPC = 5'd14,
      R_CONFIG = 5'd16, R_WATCHLO = 5'd18, R_WATCHHI = 5'd19, R_TAGLO = 5'd28,
      R_TAGHI = 5'd29, R_ERREPC = 5'd30;

   typedef struct packed {
      logic [11:0] mask;
      logic [18:0] vpn2;
      logic [7:0]  asid;
      logic        g;
   } tag_type;

   typedef struct packed {
      logic [18:0] hvpn;
      logic [7:0]  hasid;
   } probe_type;

   function automatic logic [28:0] pack_page(input logic [31:0] lo);
      return {lo[29:6], lo[5:3], lo[2], lo[1]};
   endfunction

   function automatic logic [31:0] unpack_page(input logic [28:0] pg, input logic g);
      return {2'b00, pg[28:5], pg[4:2], pg[1], pg[0], g};
   endfunction

   function automatic logic tag_match(input tag_type t, input probe_type p);
      logic [18:0] keep;
      keep = ~{7'd0, t.mask};
      return ((t.vpn2 & keep) == (p.hvpn & keep)) && (t.g || t.asid == p.hasid);
   endfunction
endpackage

// File: rtl/sctlb_if.sv
`timescale 1ns / 1ps
interface sctlb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [4:0]  reg_number;
   logic [31:0] write_data;
   modport source(output valid, opcode, reg_number, write_data, input ready);
   modport sink(input valid, opcode, reg_number, write_data, output ready);
endinterface

interface sctlb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] read_data;
   logic               unimplemented;
   logic               jump_valid;
   logic [31:0]        jump_target;
   logic               timer_changed;
   logic               recheck_interrupts;
   modport source(output valid, read_data, unimplemented, jump_valid, jump_target,
                  timer_changed, recheck_interrupts, input ready);
   modport sink(input valid, read_data, unimplemented, jump_valid, jump_target,
                timer_changed, recheck_interrupts, output ready);
endinterface

// File: rtl/sctlb_cell.sv
`timescale 1ns / 1ps
// One TLB entry; shifts a probe token and a running hit toward higher entries.
module sctlb_cell #(
   parameter int IDX = 0,
   parameter int AW = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  sctlb_pkg::tag_type  wr_tag,
   input  logic [28:0]         wr_even,
   input  logic [28:0]         wr_odd,
   input  sctlb_pkg::probe_type probe,
   input  logic                tok_i,
   input  logic                hit_i,
   input  logic [AW-1:0]       hidx_i,
   output logic                tok_o,
   output logic                hit_o,
   output logic [AW-1:0]       hidx_o,
   output sctlb_pkg::tag_type  tag_o,
   output logic [28:0]         even_o,
   output logic [28:0]         odd_o
);
   import sctlb_pkg::*;
   tag_type     tag_ff;
   logic [28:0] even_ff, odd_ff;
   logic        tok_ff, hit_ff;
   logic [AW-1:0] hidx_ff;
   logic        m;

   assign m = tag_match(tag_ff, probe);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0; even_ff <= '0; odd_ff <= '0;
         tok_ff <= 1'b0; hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            tag_ff <= wr_tag; even_ff <= wr_even; odd_ff <= wr_odd;
         end
         tok_ff <= tok_i;
         hit_ff <= hit_i | (tok_i & m);
      end
      hidx_ff <= hit_i ? hidx_i : AW'(IDX);
   end

   assign tok_o = tok_ff;
   assign hit_o = hit_ff;
   assign hidx_o = hidx_ff;
   assign tag_o = tag_ff;
   assign even_o = even_ff;
   assign odd_o = odd_ff;
endmodule

// File: rtl/system_coprocessor_tlb_unit.sv
`timescale 1ns / 1ps
// System coprocessor register file and paired-page TLB.
// req channel: one coprocessor instruction per beat (opcode, reg_number,
// write_data). rsp channel: exactly one result beat per request.
// Move-from, move-to, TLB read, TLB write and exception return results
// are registered the cycle after acceptance.
// TLB probe runs a token down the chain of TLB_ENTRIES entry cells, one
// cell per cycle, carrying the first hit.
// One instruction is in flight at a time; req_ready is low while a probe
// scans and while the result register holds an undelivered beat.
// The result register holds its beat until rsp_ready.
// Synchronous reset clears all coprocessor registers and TLB entries to zero and
// empties the result register.
module system_coprocessor_tlb_unit #(
   parameter int TLB_ENTRIES = sctlb_pkg::TLB_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   sctlb_req_if.sink   req,
   sctlb_rsp_if.source rsp
);
   import sctlb_pkg::*;
   localparam int AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   state_type state_ff, state_in;
   logic [31:0] regs_ff [NREGS];
   logic        rv_ff;
   logic signed [31:0] rd_ff;
   logic        un_ff, jv_ff, tc_ff, ri_ff;
   logic [31:0] jt_ff;

   logic [TLB_ENTRIES:0] tok, hit;
   logic [AW-1:0] hidx [TLB_ENTRIES+1];
   tag_type       tags [TLB_ENTRIES];
   logic [28:0]   evens [TLB_ENTRIES], odds [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] wr_en;

   logic acc;
   op_type op;
   logic [IDX_W-1:0] idx5;
   logic idx_ok;
   logic mt_ok;
   tag_type wtag;
   probe_type pr;

   assign op = op_type'(req.opcode);
   assign acc = req.valid & req.ready;
   assign req.ready = (state_ff == ST_IDLE) & ~rv_ff;
   assign idx5 = regs_ff[R_INDEX][IDX_W-1:0];
   assign idx_ok = 32'(idx5) < TLB_ENTRIES;
   assign wtag = '{mask: regs_ff[R_PMASK][24:13], vpn2: regs_ff[R_HI][31:13],
                   asid: regs_ff[R_HI][7:0], g: regs_ff[R_LO0][0] & regs_ff[R_LO1][0]};
   assign pr = '{hvpn: regs_ff[R_HI][31:13], hasid: regs_ff[R_HI][7:0]};

   assign tok[0] = acc && op == OP_TLBP;
   assign hit[0] = 1'b0;
   assign hidx[0] = '0;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      assign wr_en[i] = acc && op == OP_TLB_WRITE && idx_ok && 32'(idx5) == i;
      sctlb_cell #(.IDX(i), .AW(AW)) u_cell (
         .clock, .reset, .wr_en(wr_en[i]), .wr_tag(wtag),
         .wr_even(pack_page(regs_ff[R_LO0])), .wr_odd(pack_page(regs_ff[R_LO1])),
         .probe(pr), .tok_i(tok[i]), .hit_i(hit[i]), .hidx_i(hidx[i]),
         .tok_o(tok[i+1]), .hit_o(hit[i+1]), .hidx_o(hidx[i+1]),
         .tag_o(tags[i]), .even_o(evens[i]), .odd_o(odds[i]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (tok[0]) state_in = ST_SCAN;
         ST_SCAN: if (tok[TLB_ENTRIES]) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (req.reg_number)
         R_INDEX, R_LO0, R_LO1, R_CONTEXT, R_PMASK, R_WIRED, R_COUNT, R_HI,
         R_COMPARE, R_STATUS, R_CAUSE, R_EPC, R_CONFIG, R_WATCHLO, R_WATCHHI,
         R_TAGLO, R_TAGHI: mt_ok = 1'b1;
         default: mt_ok = 1'b0;
      endcase
   end

   logic [AW-1:0] ridx;
   assign ridx = AW'(idx5);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         for (int k = 0; k < NREGS; k++) regs_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         if (state_ff == ST_SCAN && tok[TLB_ENTRIES]) begin
            rv_ff <= 1'b1;
            if (hit[TLB_ENTRIES]) regs_ff[R_INDEX] <= 32'(hidx[TLB_ENTRIES]);
         end
         if (acc) begin
            rd_ff <= (op == OP_MF) ? regs_ff[req.reg_number] : '0;
            un_ff <= (op == OP_MT) && !mt_ok;
            jv_ff <= (op == OP_ERET);
            jt_ff <= (op != OP_ERET) ? '0 :
                     regs_ff[R_STATUS][2] ? regs_ff[R_ERREPC] : regs_ff[R_EPC];
            tc_ff <= (op == OP_MT) &&
                     (req.reg_number == R_COUNT || req.reg_number == R_COMPARE);
            ri_ff <= (op == OP_ERET) || (op == OP_MT && req.reg_number == R_STATUS);
            rv_ff <= (op != OP_TLBP);
            unique case (op)
               OP_MT: begin
                  unique case (req.reg_number)
                     R_INDEX, R_LO0, R_LO1, R_PMASK, R_WIRED, R_HI, R_EPC, R_CONFIG,
                     R_WATCHLO, R_WATCHHI, R_TAGLO, R_TAGHI, R_COUNT, R_STATUS:
                        regs_ff[req.reg_number] <= req.write_data;
                     R_CONTEXT: regs_ff[R_CONTEXT] <= req.write_data & 32'hFF80_0000;
                     R_COMPARE: begin
                        regs_ff[R_COMPARE] <= req.write_data;
                        regs_ff[R_CAUSE][15] <= 1'b0;
                     end
                     R_CAUSE: regs_ff[R_CAUSE][9:8] <= 2'b00;
                     default: ;
                  endcase
               end
               OP_TLBR: if (idx_ok) begin
                  regs_ff[R_PMASK] <= {7'd0, tags[ridx].mask, 13'd0};
                  regs_ff[R_HI] <= {tags[ridx].vpn2, 5'd0, tags[ridx].asid};
                  regs_ff[R_LO0] <= unpack_page(evens[ridx], tags[ridx].g);
                  regs_ff[R_LO1] <= unpack_page(odds[ridx], tags[ridx].g);
               end
               OP_TLBP: regs_ff[R_INDEX][31] <= 1'b1;
               OP_ERET: begin
                  if (regs_ff[R_STATUS][2]) regs_ff[R_STATUS][2] <= 1'b0;
                  else regs_ff[R_STATUS][1] <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.read_data = rd_ff;
   assign rsp.unimplemented = un_ff;
   assign rsp.jump_valid = jv_ff;
   assign rsp.jump_target = jt_ff;
   assign rsp.timer_changed = tc_ff;
   assign rsp.recheck_interrupts = ri_ff;

`ifndef SYNTHESIS
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      (rv_ff || state_ff == ST_SCAN) |-> !req.ready) else $error("ready while busy");
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok)) else $error("more than one probe token");
   a_probe_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && tok[TLB_ENTRIES]) |=> rv_ff) else $error("probe lost");
`endif
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import sctlb_pkg::*;

   typedef struct {
      logic [31:0] read_data;
      logic        unimplemented;
      logic        jump_valid;
      logic [31:0] jump_target;
      logic        timer_changed;
      logic        recheck_interrupts;
   } cop_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   class cop_scoreboard;
      logic [31:0] regs[32];
      tag_type     tags[32];
      logic [28:0] even_pg[32];
      logic [28:0] odd_pg[32];
      cop_result_type pending[$];
      int          checked;

      function void clear();
         foreach (regs[i]) begin
            regs[i] = '0;
            tags[i] = '0;
            even_pg[i] = '0;
            odd_pg[i] = '0;
         end
      endfunction

      function logic [28:0] to_page(logic [31:0] lo);
         return {lo[29:6], lo[5:3], lo[2], lo[1]};
      endfunction

      function logic [31:0] from_page(logic [28:0] pg, logic g);
         return {2'b00, pg, g};
      endfunction

      function void note_instr(op_type op, logic [4:0] rn, logic [31:0] wd);
         cop_result_type r;
         logic [4:0] idx;
         logic [18:0] keep, hvpn;
         r = '{default: '0};
         idx = regs[R_INDEX][4:0];
         case (op)
            OP_MF: r.read_data = regs[rn];
            OP_MT: begin
               case (rn)
                  R_INDEX, R_LO0, R_LO1, R_PMASK, R_WIRED, R_HI, R_EPC, R_CONFIG,
                  R_WATCHLO, R_WATCHHI, R_TAGLO, R_TAGHI: regs[rn] = wd;
                  R_CONTEXT: regs[rn] = wd & 32'hFF80_0000;
                  R_COUNT: begin
                     regs[rn] = wd;
                     r.timer_changed = 1;
                  end
                  R_COMPARE: begin
                     regs[rn] = wd;
                     regs[R_CAUSE][15] = 1'b0;
                     r.timer_changed = 1;
                  end
                  R_STATUS: begin
                     regs[rn] = wd;
                     r.recheck_interrupts = 1;
                  end
                  R_CAUSE: regs[R_CAUSE][9:8] = 2'b00;
                  default: r.unimplemented = 1;
               endcase
            end
            OP_TLBR: begin
               regs[R_PMASK] = {7'd0, tags[idx].mask, 13'd0};
               regs[R_HI] = {tags[idx].vpn2, 5'd0, tags[idx].asid};
               regs[R_LO0] = from_page(even_pg[idx], tags[idx].g);
               regs[R_LO1] = from_page(odd_pg[idx], tags[idx].g);
            end
            OP_TLB_WRITE: begin
               tags[idx].g = regs[R_LO0][0] & regs[R_LO1][0];
               tags[idx].asid = regs[R_HI][7:0];
               tags[idx].vpn2 = regs[R_HI][31:13];
               tags[idx].mask = regs[R_PMASK][24:13];
               even_pg[idx] = to_page(regs[R_LO0]);
               odd_pg[idx] = to_page(regs[R_LO1]);
            end
            OP_TLBP: begin
               hvpn = regs[R_HI][31:13];
               regs[R_INDEX][31] = 1'b1;
               for (int i = 0; i < 32; i++) begin
                  keep = ~{7'd0, tags[i].mask};
                  if ((tags[i].vpn2 & keep) == (hvpn & keep) &&
                      (tags[i].g || tags[i].asid == regs[R_HI][7:0])) begin
                     regs[R_INDEX] = 32'(i);
                     break;
                  end
               end
            end
            OP_ERET: begin
               if (regs[R_STATUS][2]) begin
                  r.jump_target = regs[R_ERREPC];
                  regs[R_STATUS][2] = 1'b0;
               end else begin
                  r.jump_target = regs[R_EPC];
                  regs[R_STATUS][1] = 1'b0;
               end
               r.jump_valid = 1;
               r.recheck_interrupts = 1;
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      task check_result(cop_result_type got);
         cop_result_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected beat", got.read_data, 32'd0);
            return;
         end
         w = pending.pop_front();
         checked++;
         if (got.read_data !== w.read_data)
            report_mismatch("read_data", got.read_data, w.read_data);
         if (got.unimplemented !== w.unimplemented)
            report_mismatch("unimplemented", 32'(got.unimplemented),
                            32'(w.unimplemented));
         if (got.jump_valid !== w.jump_valid)
            report_mismatch("jump_valid", 32'(got.jump_valid), 32'(w.jump_valid));
         if (got.jump_target !== w.jump_target)
            report_mismatch("jump_target", got.jump_target, w.jump_target);
         if (got.timer_changed !== w.timer_changed)
            report_mismatch("timer_changed", 32'(got.timer_changed),
                            32'(w.timer_changed));
         if (got.recheck_interrupts !== w.recheck_interrupts)
            report_mismatch("recheck_interrupts", 32'(got.recheck_interrupts),
                            32'(w.recheck_interrupts));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   sctlb_req_if req();
   sctlb_rsp_if rsp();
   cop_scoreboard sb = new();
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   int sent = 0;

   system_coprocessor_tlb_unit u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result('{rsp.read_data, rsp.unimplemented, rsp.jump_valid,
                           rsp.jump_target, rsp.timer_changed, rsp.recheck_interrupts});
      if (!reset && req.valid && req.ready)
         sb.note_instr(op_type'(req.opcode), req.reg_number, req.write_data);
   end

   // result side stalls
   initial begin
      int n;
      rsp.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            repeat (60) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp.ready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp.ready <= 1;
            @(negedge clock);
         end
      end
   end

   task automatic send_beat(input logic [2:0] op, input logic [4:0] rn,
                            input logic [31:0] wd);
      int n;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req.valid <= 0;
         repeat (n) @(negedge clock);
      end
      req.valid <= 1;
      req.opcode <= op;
      req.reg_number <= rn;
      req.write_data <= wd;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_entry(input logic [4:0] idx);
      logic [31:0] hi;
      logic [31:0] ix;
      hi = ($urandom_range(0, 7) == 0) ? $urandom :
           ((32'($urandom_range(0, 3)) << 13) | 32'($urandom_range(0, 3)));
      ix = ((($urandom_range(0, 1) != 0) ? $urandom : 32'h0) & 32'hFFFF_FFE0) | 32'(idx);
      send_beat(OP_MT, R_HI, hi);
      send_beat(OP_MT, R_PMASK, $urandom_range(0, 3) == 0 ? $urandom : 32'h0);
      send_beat(OP_MT, R_LO0, rand_word());
      send_beat(OP_MT, R_LO1, rand_word());
      send_beat(OP_MT, R_INDEX, ix);
      send_beat(OP_TLB_WRITE, 5'd0, $urandom);
   endtask

   initial begin
      int k;
      req.valid = 0;
      req.opcode = 0;
      req.reg_number = 0;
      req.write_data = 0;
      sb.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      for (int op = 0; op < 8; op++) send_beat(3'(op), 5'd31, 32'hFFFF_FFFF);
      send_beat(OP_MT, R_STATUS, 32'h0000_0006);
      send_beat(OP_MT, R_ERREPC, 32'h8000_1234);
      send_beat(OP_MT, R_EPC, 32'hBFC0_0000);
      send_beat(OP_ERET, 5'd0, 32'd0);
      send_beat(OP_ERET, 5'd0, 32'd0);
      send_beat(OP_MT, R_CONTEXT, 32'hFFFF_FFFF);
      send_beat(OP_MF, R_CONTEXT, 32'd0);
      send_beat(OP_MT, R_COMPARE, 32'h0);
      send_beat(OP_MT, R_CAUSE, 32'hFFFF_FFFF);
      send_beat(OP_MT, R_COUNT, 32'hFFFF_FFFF);
      send_beat(OP_MT, R_INDEX, 32'h0000_001F);
      send_beat(OP_TLB_WRITE, 5'd0, 32'd0);
      send_beat(OP_TLBR, 5'd0, 32'd0);
      send_beat(OP_TLBP, 5'd0, 32'd0);
      send_beat(OP_MF, R_INDEX, 32'd0);

      while (sent < 1600) begin
         if (sent > 1300) quiet_phase = 1;
         if (sent > 400 && sent < 420) hold_rsp = 1;
         k = $urandom_range(0, 9);
         if (k < 3) write_entry(5'($urandom_range(0, 31)));
         else if (k < 5) begin
            send_beat(OP_MT, R_HI, $urandom_range(0, 1) ? $urandom :
                      ($urandom_range(0, 3) << 13) | $urandom_range(0, 3));
            send_beat(OP_TLBP, 5'd0, $urandom);
            send_beat(OP_MF, R_INDEX, 32'd0);
         end else if (k < 6) begin
            send_beat(OP_TLBR, 5'd0, 32'd0);
            send_beat(OP_MF, $urandom_range(0, 1) ? R_HI : 5'($urandom_range(2, 5)), 32'd0);
         end else
            send_beat(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), rand_word());
      end
      req.valid <= 0;

      k = 0;
      while (sb.pending.size() != 0 && k < 10000) begin
         @(posedge clock);
         k++;
      end
      repeat (50) @(posedge clock);
      $display("Covered %0d instructions, %0d results checked: register moves,",
               sent, sb.checked);
      $display("TLB write/read/probe, exception returns and a long result stall.");
      if (error_count == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
